[rtl/dfsc_pkg.sv]
// Shared types and constants for the dual FIFO serial card glue.
// No dependencies; dfsc_ctrl, dfsc_dp and the top level import this package.
package dfsc_pkg;

  localparam int RAM_BYTES = 1024;
  localparam int RAM_AW    = 10;

  localparam logic [2:0] CMD_HOST_RD  = 3'd0;
  localparam logic [2:0] CMD_HOST_WR  = 3'd1;
  localparam logic [2:0] CMD_MCU_RD   = 3'd2;
  localparam logic [2:0] CMD_MCU_WR   = 3'd3;
  localparam logic [2:0] CMD_PORT2_WR = 3'd4;
  localparam logic [2:0] CMD_PORT1_RD = 3'd5;

  // MCU glue register selects (io address bits 1..0).
  localparam logic [1:0] MREG_FIFO  = 2'd0;
  localparam logic [1:0] MREG_HS    = 2'd1;
  localparam logic [1:0] MREG_CLEAR = 2'd2;
  localparam logic [1:0] MREG_MISC  = 2'd3;

  // JK control of the rx interrupt flip-flop (io address bits 4..3).
  localparam logic [1:0] JK_CLEAR  = 2'd0;
  localparam logic [1:0] JK_TOGGLE = 2'd1;
  localparam logic [1:0] JK_SET    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EXEC,
    ST_WAIT2,
    ST_PEEK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic peek;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_peek;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/dfsc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dfsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dfsc_ctrl.sv]
// Sequencer for the glue block: steps one access through read, execute,
// optional head peek and result hand-off. Depends on dfsc_pkg.
module dfsc_ctrl import dfsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = status.need_peek ? ST_WAIT2 : ST_DONE;
      end
      ST_WAIT2: begin
        state_nxt = ST_PEEK;
      end
      ST_PEEK: begin
        cmd.peek  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/dfsc_dp.sv]
// Datapath of the glue block: FIFOs, mailbox, latches, paged RAM and the
// result register. Depends on dfsc_pkg and dfsc_ram.
module dfsc_dp import dfsc_pkg::*; #(
  parameter int FIFO_DEPTH      = 128,
  parameter int FIFO_FLAG_LEVEL = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_addr,
  input  logic [15:0] in_data,
  input  logic [3:0]  in_modem_lines,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_flag_even,
  output logic        out_flag_odd,
  output logic        out_status_even,
  output logic        out_status_odd,
  output logic        out_irq_even,
  output logic        out_irq_odd,
  output logic        out_mcu_irq,
  output logic [7:0]  out_handshake_out,
  output logic [3:0]  out_rx_rate_select,
  output logic [3:0]  out_tx_rate_select,
  output logic        out_mcu_reset_pulse
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic at_flag(input logic [CW-1:0] c);
    at_flag = (32'(c) >= 32'(FIFO_FLAG_LEVEL));
  endfunction

  // Captured access.
  logic [2:0]  cmd_r;
  logic [7:0]  addr_r;
  logic [15:0] data_r;
  logic [3:0]  modem_r;

  // Block state.
  logic [PW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [CW-1:0] tx_cnt_r, tx_cnt_nxt;
  logic [PW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [8:0]    hold_r, hold_nxt;
  logic          hold_pend_r, hold_pend_nxt;
  logic          ovr_r, ovr_nxt;
  logic          rx_b8_r, rx_b8_nxt;
  logic          rx_irq_r, rx_irq_nxt;
  logic          hie_r, hie_nxt;
  logic          tie_r, tie_nxt;
  logic [7:0]    mb_word_r, mb_word_nxt;
  logic          mb_sel_r, mb_sel_nxt;
  logic          mb_pend_r, mb_pend_nxt;
  logic [7:0]    p2_r, p2_nxt;
  logic [7:0]    hs_r, hs_nxt;
  logic [7:0]    rates_r, rates_nxt;
  logic          loop_r;
  logic [15:0]   rd_r, rd_nxt;
  logic          pulse_r, pulse_nxt;
  logic          out_valid_r;

  // Memory ports.
  logic          tx_we, rx_we, ram_we;
  logic [PW-1:0] tx_waddr, rx_waddr;
  logic [8:0]    tx_wdata, rx_wdata;
  logic [8:0]    tx_rdata, rx_rdata;
  logic [7:0]    ram_rdata;
  logic [RAM_AW-1:0] ram_idx;

  assign ram_idx = {p2_r[1:0], addr_r};

  dfsc_ram #(.WIDTH(9), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
    .raddr(tx_head_r), .rdata(tx_rdata)
  );

  dfsc_ram #(.WIDTH(9), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
    .raddr(rx_head_r), .rdata(rx_rdata)
  );

  dfsc_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_page_ram (
    .clk(clk), .we(ram_we), .waddr(ram_idx), .wdata(data_r[7:0]),
    .raddr(ram_idx), .rdata(ram_rdata)
  );

  logic [7:0] hs_act;
  logic [7:0] hs_in;
  assign hs_act = p2_r[7] ? 8'hff : hs_r;
  assign hs_in  = loop_r ? (8'hc1 | (hs_act & 8'h3e))
                         : {2'b11, modem_r[3], modem_r[2], modem_r[1], 1'b1, modem_r[0], 1'b1};

  assign status.need_peek = (cmd_r == CMD_HOST_RD) && (addr_r == 8'd0) &&
                            (32'(rx_cnt_r) > 32'd1);
  assign status.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    logic [CW-1:0] tcnt;
    logic [CW-1:0] rcnt;
    tcnt = tx_cnt_r;
    rcnt = rx_cnt_r;
    tx_head_nxt = tx_head_r;  tx_tail_nxt = tx_tail_r;  tx_cnt_nxt = tx_cnt_r;
    rx_head_nxt = rx_head_r;  rx_tail_nxt = rx_tail_r;  rx_cnt_nxt = rx_cnt_r;
    hold_nxt = hold_r;        hold_pend_nxt = hold_pend_r;
    ovr_nxt = ovr_r;          rx_b8_nxt = rx_b8_r;      rx_irq_nxt = rx_irq_r;
    hie_nxt = hie_r;          tie_nxt = tie_r;
    mb_word_nxt = mb_word_r;  mb_sel_nxt = mb_sel_r;    mb_pend_nxt = mb_pend_r;
    p2_nxt = p2_r;            hs_nxt = hs_r;            rates_nxt = rates_r;
    rd_nxt = rd_r;            pulse_nxt = pulse_r;
    tx_we = 1'b0;  tx_waddr = tx_tail_r;  tx_wdata = hold_r;
    rx_we = 1'b0;  rx_waddr = rx_tail_r;  rx_wdata = {addr_r[7], data_r[7:0]};
    ram_we = 1'b0;

    if (cmd.exec) begin
      rd_nxt    = '0;
      pulse_nxt = 1'b0;
      case (cmd_r)
        CMD_HOST_RD: begin
          if (addr_r == 8'd0) begin
            if (!at_flag(rx_cnt_r)) rx_irq_nxt = 1'b0;
            if (rx_cnt_r != '0) begin
              rd_nxt      = {7'd0, ~rx_rdata};
              rx_head_nxt = ptr_inc(rx_head_r);
              rx_cnt_nxt  = rx_cnt_r - 1'b1;
            end else begin
              rd_nxt = 16'h01ff;
            end
          end else if (addr_r == 8'd1) begin
            rd_nxt = {ovr_r, 3'd0, 1'b1, 3'd0, hie_r, 6'd0, !mb_pend_r};
          end
        end
        CMD_HOST_WR: begin
          if (addr_r == 8'd0) begin
            hold_nxt      = {data_r[8], ~data_r[7:0]};
            hold_pend_nxt = 1'b1;
            tx_wdata      = {data_r[8], ~data_r[7:0]};
            if (tx_cnt_r != CNT_FULL) begin
              tx_we         = 1'b1;
              tx_tail_nxt   = ptr_inc(tx_tail_r);
              tx_cnt_nxt    = tx_cnt_r + 1'b1;
              hold_pend_nxt = 1'b0;
            end
          end else if (addr_r == 8'd1) begin
            if (data_r[5]) begin
              pulse_nxt = 1'b1;
              hie_nxt   = 1'b0;
            end else if (p2_r[7]) begin
              hie_nxt = 1'b0;
            end else begin
              hie_nxt = data_r[7];
            end
            tie_nxt = data_r[0];
          end else if (addr_r == 8'd2 || addr_r == 8'd3) begin
            mb_sel_nxt  = (addr_r == 8'd3);
            mb_word_nxt = ~data_r[7:0];
            mb_pend_nxt = 1'b1;
          end
        end
        CMD_MCU_RD: begin
          if (p2_r[2]) begin
            rd_nxt = {8'd0, ram_rdata};
          end else if (addr_r[2]) begin
            case (addr_r[1:0])
              MREG_FIFO: begin
                if (tx_cnt_r != '0) begin
                  rd_nxt      = {8'd0, tx_rdata[7:0]};
                  tx_head_nxt = ptr_inc(tx_head_r);
                  tcnt        = tx_cnt_r - 1'b1;
                end
                tx_cnt_nxt = tcnt;
                if (hold_pend_r && tcnt != CNT_FULL) begin
                  tx_we         = 1'b1;
                  tx_tail_nxt   = ptr_inc(tx_tail_r);
                  tx_cnt_nxt    = tcnt + 1'b1;
                  hold_pend_nxt = 1'b0;
                end
              end
              MREG_HS: begin
                rd_nxt = {8'd0, hs_in};
              end
              MREG_CLEAR: begin
                rd_nxt      = 16'h00ff;
                tx_head_nxt = '0;  tx_tail_nxt = '0;  tx_cnt_nxt = '0;
                rx_head_nxt = '0;  rx_tail_nxt = '0;  rx_cnt_nxt = '0;
                if (hold_pend_r) begin
                  tx_we         = 1'b1;
                  tx_waddr      = '0;
                  tx_tail_nxt   = ptr_inc('0);
                  tx_cnt_nxt    = CW'(1);
                  hold_pend_nxt = 1'b0;
                end
              end
              MREG_MISC: begin
                rd_nxt      = {8'd0, mb_word_r};
                mb_pend_nxt = p2_r[7];
              end
              default: begin
                rd_nxt = '0;
              end
            endcase
          end
        end
        CMD_MCU_WR: begin
          if (p2_r[2]) begin
            ram_we = 1'b1;
          end else if (addr_r[2]) begin
            case (addr_r[1:0])
              MREG_FIFO: begin
                if (addr_r[6]) begin
                  if (rx_cnt_r == CNT_FULL) begin
                    ovr_nxt = 1'b1;
                  end else begin
                    rx_we       = 1'b1;
                    rx_tail_nxt = ptr_inc(rx_tail_r);
                    rcnt        = rx_cnt_r + 1'b1;
                  end
                  if (rx_cnt_r == '0) rx_b8_nxt = addr_r[7];
                end
                rx_cnt_nxt = rcnt;
                if (at_flag(rcnt)) begin
                  rx_irq_nxt = 1'b1;
                end else begin
                  case (addr_r[4:3])
                    JK_CLEAR:  rx_irq_nxt = 1'b0;
                    JK_TOGGLE: rx_irq_nxt = !rx_irq_r;
                    JK_SET:    rx_irq_nxt = 1'b1;
                    default:   rx_irq_nxt = rx_irq_r;
                  endcase
                end
              end
              MREG_HS:    hs_nxt    = data_r[7:0];
              MREG_CLEAR: ovr_nxt   = 1'b0;
              MREG_MISC:  rates_nxt = data_r[7:0];
              default:    rates_nxt = rates_r;
            endcase
          end
        end
        CMD_PORT2_WR: begin
          p2_nxt = data_r[7:0];
          if (data_r[7] && !p2_r[7]) mb_pend_nxt = 1'b1;
        end
        CMD_PORT1_RD: begin
          rd_nxt = {8'd0, (tx_cnt_r != '0) && tx_rdata[8], !ovr_r, rx_cnt_r != '0,
                    mb_sel_r, at_flag(tx_cnt_r), tx_cnt_r != '0, at_flag(rx_cnt_r),
                    rx_cnt_r != CNT_FULL};
        end
        default: begin
          rd_nxt = '0;
        end
      endcase
    end

    if (cmd.peek) begin
      rx_b8_nxt = rx_rdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_addr;
      data_r  <= in_data;
      modem_r <= in_modem_lines;
    end
    rd_r    <= rd_nxt;
    pulse_r <= pulse_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= '0;  tx_tail_r <= '0;  tx_cnt_r <= '0;
      rx_head_r <= '0;  rx_tail_r <= '0;  rx_cnt_r <= '0;
      hold_r <= '0;     hold_pend_r <= 1'b0;
      ovr_r <= 1'b0;    rx_b8_r <= 1'b0;  rx_irq_r <= 1'b0;
      hie_r <= 1'b0;    tie_r <= 1'b0;
      mb_word_r <= '0;  mb_sel_r <= 1'b0; mb_pend_r <= 1'b0;
      p2_r <= '0;       hs_r <= '0;       rates_r <= '0;
      loop_r <= 1'b0;
    end else begin
      tx_head_r <= tx_head_nxt;  tx_tail_r <= tx_tail_nxt;  tx_cnt_r <= tx_cnt_nxt;
      rx_head_r <= rx_head_nxt;  rx_tail_r <= rx_tail_nxt;  rx_cnt_r <= rx_cnt_nxt;
      hold_r <= hold_nxt;        hold_pend_r <= hold_pend_nxt;
      ovr_r <= ovr_nxt;          rx_b8_r <= rx_b8_nxt;      rx_irq_r <= rx_irq_nxt;
      hie_r <= hie_nxt;          tie_r <= tie_nxt;
      mb_word_r <= mb_word_nxt;  mb_sel_r <= mb_sel_nxt;    mb_pend_r <= mb_pend_nxt;
      p2_r <= p2_nxt;            hs_r <= hs_nxt;            rates_r <= rates_nxt;
      if (cfg_wr_en) loop_r <= cfg_wr_data;
    end
  end

  // Result register: flag and interrupt lines are sampled after all updates.
  logic irq;
  assign irq = hie_r && !mb_pend_r && (rx_irq_r || (tie_r && !at_flag(tx_cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_data       <= rd_r;
      out_flag_even       <= !mb_pend_r && (tx_cnt_r != CNT_FULL) && p2_r[6];
      out_flag_odd        <= !mb_pend_r && (rx_cnt_r != '0);
      out_status_even     <= !p2_r[5];
      out_status_odd      <= !ovr_r && rx_b8_r;
      out_irq_even        <= irq && !rx_irq_r;
      out_irq_odd         <= irq && rx_irq_r;
      out_mcu_irq         <= mb_pend_r;
      out_handshake_out   <= hs_act;
      out_rx_rate_select  <= rates_r[7:4];
      out_tx_rate_select  <= rates_r[3:0];
      out_mcu_reset_pulse <= pulse_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/dual_fifo_serial_card_glue.sv]
// Top level of the host / microcontroller glue of a serial interface card.
// Depends on dfsc_pkg, dfsc_ctrl, dfsc_dp and (through the datapath) dfsc_ram.
//
// Each input beat is one access: a host register read or write, an MCU io
// read or write, an MCU port-2 write or an MCU port-1 status read. Every
// access yields exactly one result beat carrying read data together with the
// host flag, status and interrupt lines, the MCU interrupt, the handshake
// output latch and the baud-rate selects as they stand after the access.
// An access goes from acceptance through the wait, execute and done states
// into the output register; a host pop that leaves the receive FIFO
// non-empty adds a second wait and a peek state, as the new head word must
// pass once more through the registered read port of the FIFO memories.
// A new beat is taken only in the cycle after the previous result is loaded.
// The result register lets one finished result wait under out_stall while the
// next access is accepted and processed; processing halts before loading its
// result until the waiting beat is taken.
// Synchronous reset empties both FIFOs and clears every latch, the mailbox and
// the loopback setting; the FIFO stores and paged RAM keep their contents and
// need no clearing pass. cfg_wr_en writes the loopback bit; the user is to do
// so only at idle times, which the block does not enforce.
module dual_fifo_serial_card_glue import dfsc_pkg::*; #(
  parameter int FIFO_DEPTH      = 128,
  parameter int FIFO_FLAG_LEVEL = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_addr,
  input  logic [15:0] in_data,
  input  logic [3:0]  in_modem_lines,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic        out_flag_even,
  output logic        out_flag_odd,
  output logic        out_status_even,
  output logic        out_status_odd,
  output logic        out_irq_even,
  output logic        out_irq_odd,
  output logic        out_mcu_irq,
  output logic [7:0]  out_handshake_out,
  output logic [3:0]  out_rx_rate_select,
  output logic [3:0]  out_tx_rate_select,
  output logic        out_mcu_reset_pulse
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The sequencer walks each access through its phases.
  dfsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  // The datapath holds all card state and the result register.
  dfsc_dp #(.FIFO_DEPTH(FIFO_DEPTH), .FIFO_FLAG_LEVEL(FIFO_FLAG_LEVEL)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_cmd(in_cmd), .in_addr(in_addr), .in_data(in_data),
    .in_modem_lines(in_modem_lines),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_flag_even(out_flag_even), .out_flag_odd(out_flag_odd),
    .out_status_even(out_status_even), .out_status_odd(out_status_odd),
    .out_irq_even(out_irq_even), .out_irq_odd(out_irq_odd),
    .out_mcu_irq(out_mcu_irq), .out_handshake_out(out_handshake_out),
    .out_rx_rate_select(out_rx_rate_select),
    .out_tx_rate_select(out_tx_rate_select),
    .out_mcu_reset_pulse(out_mcu_reset_pulse)
  );

endmodule
